/* hw/rtl/tsbuf_pkg.sv */
package tsbuf_pkg;

    localparam int DEPTH         = 64;
    localparam int TIME_WIDTH    = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int GAP_WIDTH     = 32;
    localparam int COUNT_WIDTH   = 8;
    localparam int OP_WIDTH      = 2;
    localparam int STATUS_WIDTH  = 2;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ALU_W  = (TIME_WIDTH > GAP_WIDTH) ? TIME_WIDTH : GAP_WIDTH;
    localparam int ENTRY_W = TIME_WIDTH + PAYLOAD_WIDTH;

    localparam int IN_BITS     = TIME_WIDTH + PAYLOAD_WIDTH + TIME_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = TIME_WIDTH + PAYLOAD_WIDTH + COUNT_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [GAP_WIDTH-1:0] GAP_RESET = GAP_WIDTH'(100);

    localparam logic [OP_WIDTH-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_WIDTH-1:0] OP_RANGE  = 2'd3;

    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_DROP  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd3;

    // ring position to physical slot, pos below DEPTH
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] oldest,
                                                  input logic [ADDR_W-1:0] pos);
        logic [ADDR_W:0] sum;
        begin
            sum = {1'b0, oldest} + {1'b0, pos};
            if (sum >= (ADDR_W + 1)'(DEPTH))
            begin
                sum = sum - (ADDR_W + 1)'(DEPTH);
            end
            slot_of = sum[ADDR_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/timestamped_sample_buffer_nearest_lookup_core.sv */
// Timestamped sample ring with nearest-time lookup.
//
// Input stream s_axis: tuser carries the operation (put, delete oldest, nearest
// lookup, range count), tdata carries timestamp, payload and end time. Every input
// transfer yields exactly one result transfer on m_axis: tuser is the status, tdata
// the found time, found payload and signed range count. The user writes max_gap via
// cfg_valid/cfg_data only while the block is idle; the block does not enforce this.
//
// The block works on one item at a time. A single sample memory with one
// registered read port and one shared subtractor/comparator serve every step.
// Lookups binary-search the filled entries; a range count runs two searches.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver only holds the block once a second result is
// ready. Reset empties the ring, clears the last put time, sets max_gap to
// 100 and drops any pending result. Stored samples are not cleared.
module timestamped_sample_buffer_nearest_lookup_core
    import tsbuf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // timestamp, payload, end_time
    input  logic [OP_WIDTH-1:0]     s_axis_tuser,   // operation

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // found_time, found_payload, count
    output logic [STATUS_WIDTH-1:0] m_axis_tuser,   // status

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [GAP_WIDTH-1:0]    cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_PUT2     = 4'd2;
    localparam logic [3:0] S_RD_OLD   = 4'd3;
    localparam logic [3:0] S_RD_NEW   = 4'd4;
    localparam logic [3:0] S_CHK      = 4'd5;
    localparam logic [3:0] S_SRCH     = 4'd6;
    localparam logic [3:0] S_SCMP     = 4'd7;
    localparam logic [3:0] S_NB       = 4'd8;
    localparam logic [3:0] S_NB1      = 4'd9;
    localparam logic [3:0] S_NB2      = 4'd10;
    localparam logic [3:0] S_NB3      = 4'd11;
    localparam logic [3:0] S_POSDONE  = 4'd12;
    localparam logic [3:0] S_FETCH    = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    localparam int DW = (ADDR_W + 2 > COUNT_WIDTH + 1) ? ADDR_W + 2 : COUNT_WIDTH + 1;
    localparam logic signed [DW-1:0] C_MAX = DW'((2 ** (COUNT_WIDTH - 1)) - 1);
    localparam logic signed [DW-1:0] C_MIN = -DW'(2 ** (COUNT_WIDTH - 1));

    // control state
    logic [3:0]               state_reg, state_next;
    logic [ADDR_W-1:0]        oldest_reg, oldest_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [TIME_WIDTH-1:0]    last_put_reg, last_put_next;
    logic [GAP_WIDTH-1:0]     gap_reg, gap_next;
    logic                     out_valid_reg, out_valid_next;

    // working registers
    logic [OP_WIDTH-1:0]      op_reg, op_next;
    logic [TIME_WIDTH-1:0]    t_reg, t_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [TIME_WIDTH-1:0]    te_reg, te_next;
    logic [TIME_WIDTH-1:0]    key_reg, key_next;
    logic [TIME_WIDTH-1:0]    t_lo_reg, t_lo_next;
    logic [TIME_WIDTH-1:0]    t_hi_reg, t_hi_next;
    logic [ALU_W-1:0]         acc_a_reg, acc_a_next;
    logic [ALU_W-1:0]         acc_b_reg, acc_b_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic [ADDR_W-1:0]        pos_a_reg, pos_a_next;
    logic                     pass_reg, pass_next;
    logic [1:0]               chk_reg, chk_next;
    logic                     fail_reg, fail_next;
    logic                     put_ok_reg, put_ok_next;

    logic [STATUS_WIDTH-1:0]  res_status_reg, res_status_next;
    logic [TIME_WIDTH-1:0]    res_time_reg, res_time_next;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg, res_pay_next;
    logic [COUNT_WIDTH-1:0]   res_count_reg, res_count_next;

    logic [STATUS_WIDTH-1:0]  out_status_reg, out_status_next;
    logic [TIME_WIDTH-1:0]    out_time_reg, out_time_next;
    logic [PAYLOAD_WIDTH-1:0] out_pay_reg, out_pay_next;
    logic [COUNT_WIDTH-1:0]   out_count_reg, out_count_next;

    // sample memory
    logic [ENTRY_W-1:0]       mem [DEPTH];
    logic [ENTRY_W-1:0]       rdata_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [TIME_WIDTH-1:0]    rd_time;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;

    // shared subtractor
    logic [ALU_W-1:0]         alu_a, alu_b;
    logic [ALU_W:0]           alu_diff;
    logic                     alu_borrow;

    logic                     in_xfer;
    logic [CNT_W-1:0]         mid_calc;
    logic [CNT_W-1:0]         lo_m1;
    logic signed [DW-1:0]     cnt_diff;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_count_reg, out_pay_reg, out_time_reg});

    assign rd_time = rdata_reg[TIME_WIDTH-1:0];
    assign rd_pay  = rdata_reg[ENTRY_W-1:TIME_WIDTH];

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1    = lo_reg - CNT_W'(1);
    assign cnt_diff = $signed(DW'(pos_reg)) - $signed(DW'(pos_a_reg));

    always_comb
    begin
        alu_a = t_reg;
        alu_b = last_put_reg;
        case (state_reg)
            S_PUT2:
            begin
                alu_a = acc_a_reg;
                alu_b = ALU_W'(gap_reg);
            end
            S_CHK:
            begin
                case (chk_reg)
                    2'd0:
                    begin
                        alu_a = ALU_W'(t_reg);
                        alu_b = ALU_W'(t_lo_reg);
                    end
                    2'd1:
                    begin
                        alu_a = ALU_W'(t_hi_reg);
                        alu_b = ALU_W'(t_reg);
                    end
                    2'd2:
                    begin
                        alu_a = ALU_W'(te_reg);
                        alu_b = ALU_W'(t_lo_reg);
                    end
                    default:
                    begin
                        alu_a = ALU_W'(t_hi_reg);
                        alu_b = ALU_W'(te_reg);
                    end
                endcase
            end
            S_SCMP, S_NB2:
            begin
                alu_a = ALU_W'(rd_time);
                alu_b = ALU_W'(key_reg);
            end
            S_NB1:
            begin
                alu_a = ALU_W'(key_reg);
                alu_b = ALU_W'(rd_time);
            end
            S_NB3:
            begin
                alu_a = acc_a_reg;
                alu_b = acc_b_reg;
            end
            default:
            begin
                alu_a = ALU_W'(t_reg);
                alu_b = ALU_W'(last_put_reg);
            end
        endcase
        alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
        alu_borrow = alu_diff[ALU_W];
    end

    always_comb
    begin
        mem_raddr = oldest_reg;
        case (state_reg)
            S_RD_OLD:  mem_raddr = slot_of(oldest_reg, ADDR_W'(fill_reg - CNT_W'(1)));
            S_SRCH:    mem_raddr = slot_of(oldest_reg, mid_calc[ADDR_W-1:0]);
            S_NB:      mem_raddr = slot_of(oldest_reg, lo_m1[ADDR_W-1:0]);
            S_NB1:     mem_raddr = slot_of(oldest_reg, lo_reg[ADDR_W-1:0]);
            S_POSDONE: mem_raddr = slot_of(oldest_reg, pos_reg);
            default:   mem_raddr = oldest_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        fill_next       = fill_reg;
        last_put_next   = last_put_reg;
        gap_next        = gap_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        t_next          = t_reg;
        pay_next        = pay_reg;
        te_next         = te_reg;
        key_next        = key_reg;
        t_lo_next       = t_lo_reg;
        t_hi_next       = t_hi_reg;
        acc_a_next      = acc_a_reg;
        acc_b_next      = acc_b_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        pos_a_next      = pos_a_reg;
        pass_next       = pass_reg;
        chk_next        = chk_reg;
        fail_next       = fail_reg;
        put_ok_next     = put_ok_reg;
        res_status_next = res_status_reg;
        res_time_next   = res_time_reg;
        res_pay_next    = res_pay_reg;
        res_count_next  = res_count_reg;
        out_status_next = out_status_reg;
        out_time_next   = out_time_reg;
        out_pay_next    = out_pay_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = oldest_reg;

        if (cfg_valid && cfg_ready)
        begin
            gap_next = cfg_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = s_axis_tuser;
                    t_next     = s_axis_tdata[TIME_WIDTH-1:0];
                    pay_next   = s_axis_tdata[TIME_WIDTH+PAYLOAD_WIDTH-1:TIME_WIDTH];
                    te_next    = s_axis_tdata[IN_BITS-1:TIME_WIDTH+PAYLOAD_WIDTH];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_status_next = ST_OK;
                res_time_next   = '0;
                res_pay_next    = '0;
                res_count_next  = '0;
                case (op_reg)
                    OP_PUT:
                    begin
                        // later than the last put: no borrow and nonzero step
                        acc_a_next  = ALU_W'(alu_diff[TIME_WIDTH-1:0]);
                        put_ok_next = !alu_borrow && (alu_diff[ALU_W-1:0] != '0);
                        state_next  = S_PUT2;
                    end
                    OP_DELETE:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            oldest_next = slot_of(oldest_reg, ADDR_W'(1));
                            fill_next   = fill_reg - CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD_OLD;
                        end
                    end
                endcase
            end
            S_PUT2:
            begin
                if (put_ok_reg && alu_borrow)
                begin
                    mem_we = 1'b1;
                    if (fill_reg >= CNT_W'(DEPTH))
                    begin
                        mem_waddr   = oldest_reg;
                        oldest_next = slot_of(oldest_reg, ADDR_W'(1));
                    end
                    else
                    begin
                        mem_waddr = slot_of(oldest_reg, fill_reg[ADDR_W-1:0]);
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    res_status_next = ST_DROP;
                end
                last_put_next = t_reg;
                state_next    = S_DONE;
            end
            S_RD_OLD:
            begin
                t_lo_next  = rd_time;
                state_next = S_RD_NEW;
            end
            S_RD_NEW:
            begin
                t_hi_next  = rd_time;
                chk_next   = 2'd0;
                fail_next  = 1'b0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // span checks: start >= oldest, start <= newest, then end time
                fail_next = fail_reg || alu_borrow;
                chk_next  = chk_reg + 2'd1;
                if ((chk_reg == 2'd3) || ((chk_reg == 2'd1) && (op_reg == OP_LOOKUP)))
                begin
                    if (fail_reg || alu_borrow)
                    begin
                        res_status_next = ST_MISS;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        key_next   = t_reg;
                        lo_next    = '0;
                        hi_next    = fill_reg;
                        pass_next  = 1'b0;
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_SCMP;
                end
                else
                begin
                    state_next = S_NB;
                end
            end
            S_SCMP:
            begin
                if (alu_borrow)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_NB:
            begin
                if (lo_reg >= fill_reg)
                begin
                    pos_next   = ADDR_W'(fill_reg - CNT_W'(1));
                    state_next = S_POSDONE;
                end
                else if (lo_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = S_POSDONE;
                end
                else
                begin
                    state_next = S_NB1;
                end
            end
            S_NB1:
            begin
                acc_a_next = ALU_W'(alu_diff[TIME_WIDTH-1:0]);
                state_next = S_NB2;
            end
            S_NB2:
            begin
                acc_b_next = ALU_W'(alu_diff[TIME_WIDTH-1:0]);
                state_next = S_NB3;
            end
            S_NB3:
            begin
                // tie goes to the later entry
                pos_next   = alu_borrow ? lo_m1[ADDR_W-1:0] : lo_reg[ADDR_W-1:0];
                state_next = S_POSDONE;
            end
            S_POSDONE:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    state_next = S_FETCH;
                end
                else if (!pass_reg)
                begin
                    pos_a_next = pos_reg;
                    key_next   = te_reg;
                    lo_next    = '0;
                    hi_next    = fill_reg;
                    pass_next  = 1'b1;
                    state_next = S_SRCH;
                end
                else
                begin
                    if (cnt_diff > C_MAX)
                    begin
                        res_count_next = COUNT_WIDTH'(C_MAX);
                    end
                    else if (cnt_diff < C_MIN)
                    begin
                        res_count_next = COUNT_WIDTH'(C_MIN);
                    end
                    else
                    begin
                        res_count_next = COUNT_WIDTH'(cnt_diff);
                    end
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                res_time_next = rd_time;
                res_pay_next  = rd_pay;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_status_next = res_status_reg;
                    out_time_next   = res_time_reg;
                    out_pay_next    = res_pay_reg;
                    out_count_next  = res_count_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            fill_reg      <= '0;
            last_put_reg  <= '0;
            gap_reg       <= GAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            fill_reg      <= fill_next;
            last_put_reg  <= last_put_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        t_reg          <= t_next;
        pay_reg        <= pay_next;
        te_reg         <= te_next;
        key_reg        <= key_next;
        t_lo_reg       <= t_lo_next;
        t_hi_reg       <= t_hi_next;
        acc_a_reg      <= acc_a_next;
        acc_b_reg      <= acc_b_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pos_reg        <= pos_next;
        pos_a_reg      <= pos_a_next;
        pass_reg       <= pass_next;
        chk_reg        <= chk_next;
        fail_reg       <= fail_next;
        put_ok_reg     <= put_ok_next;
        res_status_reg <= res_status_next;
        res_time_reg   <= res_time_next;
        res_pay_reg    <= res_pay_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_time_reg   <= out_time_next;
        out_pay_reg    <= out_pay_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {pay_reg, t_reg};
        end
        rdata_reg <= mem[mem_raddr];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond ring depth");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH || state_reg == S_SCMP) |->
            (lo_reg <= hi_reg && hi_reg <= fill_reg))
        else $error("search window outside filled entries");

    a_delete_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPATCH && op_reg == OP_DELETE && fill_reg == '0) |=>
            (fill_reg == '0 && $stable(oldest_reg)))
        else $error("delete on empty ring changed the ring");

endmodule

/* verif/tsbuf_checker.sv */
`timescale 1ns / 100ps

module tsbuf_checker
    import tsbuf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // timestamp, payload, end_time
    input  logic [OP_WIDTH-1:0]     s_axis_tuser,   // operation

    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // found_time, found_payload, count
    input  logic [STATUS_WIDTH-1:0] m_axis_tuser,   // status

    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [GAP_WIDTH-1:0]    cfg_data,

    output int                      errors,
    output int                      outstanding
);

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]  status;
        logic [TIME_WIDTH-1:0]    found_time;
        logic [PAYLOAD_WIDTH-1:0] found_payload;
        logic [COUNT_WIDTH-1:0]   count;
    } response_t;

    logic [TIME_WIDTH-1:0]    ring_time [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] ring_payload [DEPTH];
    int                       head_slot;
    int                       held;
    logic [TIME_WIDTH-1:0]    prev_put_time;
    logic [GAP_WIDTH-1:0]     gap_limit;
    response_t                pending_responses[$];
    int                       fail_total;

    function automatic int slot_at(input int pos);
        return (head_slot + pos) % DEPTH;
    endfunction

    function automatic logic covers(input logic [TIME_WIDTH-1:0] t);
        if (held == 0)
        begin
            return 1'b0;
        end
        return (t >= ring_time[slot_at(0)]) && (t <= ring_time[slot_at(held - 1)]);
    endfunction

    // first position not below t, then pick the closer neighbor, ties to the later one
    function automatic int nearest_position(input logic [TIME_WIDTH-1:0] t);
        int                    lo;
        int                    hi;
        int                    mid;
        logic [TIME_WIDTH-1:0] below;
        logic [TIME_WIDTH-1:0] above;
        lo = 0;
        hi = held;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (ring_time[slot_at(mid)] < t)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid;
            end
        end
        if (lo >= held)
        begin
            return held - 1;
        end
        if (lo == 0)
        begin
            return 0;
        end
        below = t - ring_time[slot_at(lo - 1)];
        above = ring_time[slot_at(lo)] - t;
        return (below < above) ? lo - 1 : lo;
    endfunction

    function automatic response_t ring_response(input logic [OP_WIDTH-1:0] op,
                                                input logic [IN_TDATA_W-1:0] data);
        logic [TIME_WIDTH-1:0]    t;
        logic [TIME_WIDTH-1:0]    te;
        logic [PAYLOAD_WIDTH-1:0] pay;
        response_t                r;
        int                       s;
        int                       d;
        t   = data[TIME_WIDTH-1:0];
        pay = data[TIME_WIDTH +: PAYLOAD_WIDTH];
        te  = data[TIME_WIDTH + PAYLOAD_WIDTH +: TIME_WIDTH];
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUT:
            begin
                if (prev_put_time < t && (t - prev_put_time) < gap_limit)
                begin
                    if (held >= DEPTH)
                    begin
                        // full ring: overwrite the oldest sample
                        s = head_slot;
                        head_slot = (head_slot + 1) % DEPTH;
                    end
                    else
                    begin
                        s = slot_at(held);
                        held++;
                    end
                    ring_time[s]    = t;
                    ring_payload[s] = pay;
                end
                else
                begin
                    r.status = ST_DROP;
                end
                prev_put_time = t;
            end
            OP_DELETE:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                end
            end
            OP_LOOKUP:
            begin
                if (!covers(t))
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    s = slot_at(nearest_position(t));
                    r.found_time    = ring_time[s];
                    r.found_payload = ring_payload[s];
                end
            end
            default:
            begin
                if (!covers(t) || !covers(te))
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    d = nearest_position(te) - nearest_position(t);
                    if (d > 127)
                    begin
                        d = 127;
                    end
                    if (d < -128)
                    begin
                        d = -128;
                    end
                    r.count = COUNT_WIDTH'(d);
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_response();
        response_t want;
        response_t got;
        got.status        = m_axis_tuser;
        got.found_time    = m_axis_tdata[TIME_WIDTH-1:0];
        got.found_payload = m_axis_tdata[TIME_WIDTH +: PAYLOAD_WIDTH];
        got.count         = m_axis_tdata[TIME_WIDTH + PAYLOAD_WIDTH +: COUNT_WIDTH];
        if (pending_responses.size() == 0)
        begin
            $error("result transfer with no request pending");
            fail_total++;
            return;
        end
        want = pending_responses.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_total++;
        end
        if (got.found_time !== want.found_time)
        begin
            $error("found_time: expected %0h, got %0h", want.found_time, got.found_time);
            fail_total++;
        end
        if (got.found_payload !== want.found_payload)
        begin
            $error("found_payload: expected %0h, got %0h",
                   want.found_payload, got.found_payload);
            fail_total++;
        end
        if (got.count !== want.count)
        begin
            $error("count: expected %0d, got %0d", $signed(want.count), $signed(got.count));
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot     = 0;
            held          = 0;
            prev_put_time = '0;
            gap_limit     = GAP_RESET;
            fail_total    = 0;
            pending_responses.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            // retire the older result before queueing a new request
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_response();
            end
            if (cfg_valid && cfg_ready)
            begin
                gap_limit = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_responses.push_back(ring_response(s_axis_tuser, s_axis_tdata));
            end
            errors      <= fail_total;
            outstanding <= pending_responses.size();
        end
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench
    import tsbuf_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;

    logic                    clk = 1'b0;
    logic                    rst_n;

    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // timestamp, payload, end_time
    logic [OP_WIDTH-1:0]     s_axis_tuser;   // operation

    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // found_time, found_payload, count
    logic [STATUS_WIDTH-1:0] m_axis_tuser;   // status

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [GAP_WIDTH-1:0]    cfg_data;

    int                      errors;
    int                      outstanding;
    int                      cycle_count = 0;
    bit                      no_idle = 1'b0;
    logic [GAP_WIDTH-1:0]    gap_now = GAP_RESET;
    logic [TIME_WIDTH-1:0]   stamp = '0;

    timestamped_sample_buffer_nearest_lookup_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    tsbuf_checker check_unit (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pause_len();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    // query time near the recent puts, now and then past the newest or anywhere
    function automatic logic [TIME_WIDTH-1:0] near_stamp(input logic [63:0] window);
        logic [31:0] w;
        int          pick;
        w = (window > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : window[31:0];
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return $urandom;
        end
        if (pick == 1)
        begin
            return stamp + $urandom_range(1, 5);
        end
        return stamp - $urandom_range(0, w);
    endfunction

    task automatic send(input logic [OP_WIDTH-1:0] op, input logic [TIME_WIDTH-1:0] ts,
                        input logic [PAYLOAD_WIDTH-1:0] pay, input logic [TIME_WIDTH-1:0] te);
        int n;
        n = pause_len();
        if (n > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tdata  = {te, pay, ts};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_gap(input logic [GAP_WIDTH-1:0] v);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        gap_now   = v;
    endtask

    task automatic run_phase(input int n, input logic [31:0] step_cap, input bit fresh,
                             input int del_pct);
        int          r;
        logic [31:0] step;
        logic [31:0] ts;
        logic [63:0] window;
        if (fresh)
        begin
            stamp = $urandom;
        end
        step = (gap_now > 1) ? ((gap_now - 1 < step_cap) ? gap_now - 1 : step_cap) : 32'd1;
        window = 64'(step) * 40;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                ts = stamp + $urandom_range(1, step);
                send(OP_PUT, ts, $urandom, $urandom);
                stamp = ts;
            end
            else if (r < 50)
            begin
                // repeated, backward or oversized step
                case ($urandom_range(0, 2))
                    0:       ts = stamp;
                    1:       ts = stamp - $urandom_range(1, 1000);
                    default: ts = stamp + gap_now + $urandom_range(0, 3);
                endcase
                send(OP_PUT, ts, $urandom, $urandom);
                stamp = ts;
            end
            else if (r < 50 + del_pct)
            begin
                send(OP_DELETE, $urandom, $urandom, $urandom);
            end
            else if (r < 80)
            begin
                send(OP_LOOKUP, near_stamp(window), $urandom, $urandom);
            end
            else
            begin
                send(OP_RANGE, near_stamp(window), $urandom, near_stamp(window));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int n;
            n = pause_len();
            if (n > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUT;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty ring
        send(OP_LOOKUP, 32'd0, 32'd0, 32'd0);
        send(OP_RANGE, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send(OP_DELETE, 32'd0, 32'd0, 32'd0);
        // not later than the reset put time, then a step equal to the limit
        send(OP_PUT, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_PUT, 32'd50, 32'hA5A5_A5A5, 32'd0);
        send(OP_PUT, 32'd150, 32'h1234_5678, 32'd0);
        send(OP_PUT, 32'd249, 32'h5A5A_5A5A, 32'd0);
        send(OP_PUT, 32'd249, 32'h0BAD_F00D, 32'd0);
        send(OP_PUT, 32'd260, 32'h0000_0001, 32'd0);
        send(OP_PUT, 32'd270, 32'h8000_0000, 32'd0);
        send(OP_LOOKUP, 32'd50, 32'd0, 32'd0);
        send(OP_LOOKUP, 32'd270, 32'd0, 32'd0);
        send(OP_LOOKUP, 32'd254, 32'd0, 32'd0);
        // halfway between two samples goes to the later one
        send(OP_LOOKUP, 32'd265, 32'd0, 32'd0);
        send(OP_LOOKUP, 32'd49, 32'd0, 32'd0);
        send(OP_LOOKUP, 32'd271, 32'd0, 32'd0);
        send(OP_RANGE, 32'd50, 32'd0, 32'd270);
        send(OP_RANGE, 32'd270, 32'd0, 32'd50);
        send(OP_RANGE, 32'd50, 32'd0, 32'd300);
        send(OP_DELETE, 32'd0, 32'd0, 32'd0);
        write_gap(32'hFFFF_FFFF);
        send(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send(OP_RANGE, 32'd249, 32'd0, 32'hFFFF_FFFF);
        stamp = 32'hFFFF_FFFF;

        write_gap(GAP_RESET);
        run_phase(250, 32'd99, 1'b0, 10);
        write_gap(32'd2);
        run_phase(150, 32'd1, 1'b0, 5);
        write_gap(32'hFFFF_FFFF);
        run_phase(250, 32'd1 << 24, 1'b1, 10);
        // no put can pass, the ring drains
        write_gap(32'd1);
        run_phase(80, 32'd1, 1'b0, 20);
        write_gap($urandom_range(50, 3));
        run_phase(250, 32'd64, 1'b1, 5);
        write_gap(32'd1000);
        run_phase(250, 32'd6, 1'b0, 15);
        write_gap($urandom_range(32'hFFFF_FFFF, 1));
        run_phase(200, 32'd1 << 20, 1'b1, 10);
        write_gap(GAP_RESET);
        run_phase(200, 32'd99, 1'b1, 30);

        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (60) @(negedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
